// ===== hdl/base64_stream_decoder_top_defines.svh =====
// Assertion macros for the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Check that cond implies prop in the same cycle.
`define B64D_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("base64 decoder check failed");

// Check that cond implies prop in the next cycle.
`define B64D_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("base64 decoder check failed");

`endif

// ===== hdl/b64d_pkg.sv =====
// Types, character codes and the alphabet lookup for the base64 decoder.
`default_nettype none
package b64d_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [7:0] OFFSET_LOWER = 8'd26;
  localparam logic [7:0] OFFSET_DIGIT = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [5:0] sextet;
    logic       stop;
    logic       last;
  } class_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic class_t classify(input logic [7:0] c, input logic last);
    class_t r;
    logic [7:0] v;
    r.sextet = '0;
    r.stop   = 1'b0;
    r.last   = last;
    v        = '0;
    priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = c - CHAR_UPPER_A;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = c - CHAR_LOWER_A + OFFSET_LOWER;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      v = c - CHAR_DIGIT_0 + OFFSET_DIGIT;
    end else if (c == CHAR_PLUS) begin
      v = {2'b00, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      v = {2'b00, SEXTET_SLASH};
    end else begin
      r.stop = 1'b1;
    end
    r.sextet = v[5:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b64d_front.sv =====
// Front end: accepts characters and classifies them into sextets or stops.
`default_nettype none
module b64d_front (
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       character,
  input  wire logic             message_last,
  input  wire b64d_pkg::q_stat_t q_stat,
  output logic                  push,
  output b64d_pkg::class_t      push_data
);
  import b64d_pkg::*;

  assign in_stall  = q_stat.full;
  assign push      = in_valid && !q_stat.full;
  assign push_data = classify(character, message_last);

endmodule
`default_nettype wire

// ===== hdl/b64d_queue.sv =====
// Short queue of classified characters between front and back end.
`default_nettype none
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b64d_pkg::class_t  push_data,
  input  wire logic              pop,
  output b64d_pkg::class_t       pop_data,
  output b64d_pkg::q_stat_t      q_stat
);
  import b64d_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  class_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + CNT_W'(1);
    else if (pop && !push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign pop_data     = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(DEPTH));

endmodule
`default_nettype wire

// ===== hdl/b64d_back.sv =====
// Back end: packs sextets into bytes, flushes on message end, holds the result.
`default_nettype none
module b64d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64d_pkg::q_stat_t q_stat,
  input  wire b64d_pkg::class_t  pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             byte_first,
  output logic [7:0]             byte_second,
  output logic [7:0]             byte_third,
  output logic [1:0]             byte_count,
  output logic                   message_end,
  output logic                   halted
);
  import b64d_pkg::*;

  logic [1:0]  group_fill;
  logic [17:0] pending_sextets;
  logic        stop_seen;

  logic [1:0]  group_fill_next;
  logic [17:0] pending_sextets_next;
  logic        stop_seen_next;
  logic [23:0] word;
  logic [1:0]  count;
  logic        halted_now;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    group_fill_next      = group_fill;
    pending_sextets_next = pending_sextets;
    stop_seen_next       = stop_seen;
    word                 = '0;
    count                = '0;
    if (!stop_seen) begin
      priority if (pop_data.stop) begin
        stop_seen_next = 1'b1;
      end else if (group_fill == 2'd3) begin
        word                 = {pending_sextets, pop_data.sextet};
        count                = 2'd3;
        group_fill_next      = '0;
        pending_sextets_next = '0;
      end else begin
        pending_sextets_next = {pending_sextets[11:0], pop_data.sextet};
        group_fill_next      = group_fill + 2'd1;
      end
    end
    halted_now = stop_seen_next;
    if (pop_data.last) begin
      if (count == 2'd0) begin
        unique case (group_fill_next)
          2'd2: begin
            word  = {pending_sextets_next[11:0], 12'h000};
            count = 2'd1;
          end
          2'd3: begin
            word  = {pending_sextets_next, 6'h00};
            count = 2'd2;
          end
          default: ;
        endcase
      end
      group_fill_next      = '0;
      pending_sextets_next = '0;
      stop_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill      <= '0;
      pending_sextets <= '0;
      stop_seen       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        group_fill      <= group_fill_next;
        pending_sextets <= pending_sextets_next;
        stop_seen       <= stop_seen_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_first  <= (count >= 2'd1) ? word[23:16] : 8'h00;
      byte_second <= (count >= 2'd2) ? word[15:8]  : 8'h00;
      byte_third  <= (count == 2'd3) ? word[7:0]   : 8'h00;
      byte_count  <= count;
      message_end <= pop_data.last;
      halted      <= halted_now;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/base64_stream_decoder_top.sv =====
// Top level of the streaming base64 decoder.
//
// Takes one ASCII character per transaction and returns exactly one result per
// character, carrying zero to three decoded bytes. A new character is accepted
// every cycle while the queue is not full. Each result is registered: the
// character is written into the queue and, once popped, is decoded straight
// into the result register. The rate of one per cycle is set by the group
// update in the back end. A queue of QUEUE_DEPTH entries (at least 2)
// absorbs output stalls so the input keeps flowing until it fills.
`default_nettype none
`include "base64_stream_decoder_top_defines.svh"
module base64_stream_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] character,
  input  wire logic       message_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_first,
  output logic [7:0]      byte_second,
  output logic [7:0]      byte_third,
  output logic [1:0]      byte_count,
  output logic            message_end,
  output logic            halted
);
  import b64d_pkg::*;

  q_stat_t q_stat;
  class_t  push_data;
  class_t  pop_data;
  logic    push;
  logic    pop;

  b64d_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .message_last (message_last),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .byte_third  (byte_third),
    .byte_count  (byte_count),
    .message_end (message_end),
    .halted      (halted)
  );

  `B64D_ASSERT_NOW(a_queue_status, 1'b1, !(q_stat.full && q_stat.empty))
  `B64D_ASSERT_NEXT(a_pop_gives_result, pop, out_valid)
  `B64D_ASSERT_NOW(a_full_group_not_halted, out_valid && byte_count == 2'd3, !halted)
  `B64D_ASSERT_NOW(a_unused_bytes_zero, out_valid && byte_count == 2'd0,
                   byte_first == 8'h00 && byte_second == 8'h00 && byte_third == 8'h00)

endmodule
`default_nettype wire

// ===== sim/base64_stream_decoder_top_test.sv =====
// Self-checking testbench for the streaming base64 decoder top level.
`timescale 1ns / 100ps

package b64_check_pkg;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [1:0] count;
    logic       msg_end;
    logic       stop;
  } decoded_t;

  function automatic bit sextet_of_char(input logic [7:0] c, output logic [5:0] s);
    s = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s = 6'(c - CHAR_LOWER_A + OFFSET_LOWER);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s = 6'(c - CHAR_DIGIT_0 + OFFSET_DIGIT);
    end else if (c == CHAR_PLUS) begin
      s = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s = SEXTET_SLASH;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
    if (s < 6'd26) return CHAR_UPPER_A + 8'(s);
    if (s < 6'd52) return CHAR_LOWER_A + 8'(s) - OFFSET_LOWER;
    if (s < SEXTET_PLUS) return CHAR_DIGIT_0 + 8'(s) - OFFSET_DIGIT;
    if (s == SEXTET_PLUS) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  class base64_byte_ledger;
    decoded_t   expected_bytes[$];
    logic [1:0] pend_fill;
    logic [17:0] pend_bits;
    logic       stopped;
    int         errors;
    int         checked;
    int         messages;
    int         halted_messages;
    int         bytes_decoded;

    function new();
      pend_fill = '0;
      pend_bits = '0;
      stopped   = 1'b0;
    endfunction

    function void note_character(input logic [7:0] c, input logic last);
      decoded_t    r;
      logic [23:0] word;
      logic [1:0]  cnt;
      logic [5:0]  s;
      bit          ok;
      word = '0;
      cnt  = '0;
      ok   = sextet_of_char(c, s);
      if (!stopped) begin
        if (!ok) begin
          stopped = 1'b1;
        end else if (pend_fill == 2'd3) begin
          word      = {pend_bits, s};
          cnt       = 2'd3;
          pend_fill = '0;
          pend_bits = '0;
        end else begin
          pend_bits = {pend_bits[11:0], s};
          pend_fill = pend_fill + 2'd1;
        end
      end
      r.stop = stopped;
      if (last) begin
        if (cnt == 2'd0 && pend_fill >= 2'd2) begin
          word = (pend_fill == 2'd2) ? {pend_bits[11:0], 12'b0} : {pend_bits, 6'b0};
          cnt  = pend_fill - 2'd1;
        end
        pend_fill = '0;
        pend_bits = '0;
        stopped   = 1'b0;
        messages++;
        if (r.stop) halted_messages++;
      end
      r.first   = (cnt >= 2'd1) ? word[23:16] : 8'h00;
      r.second  = (cnt >= 2'd2) ? word[15:8] : 8'h00;
      r.third   = (cnt == 2'd3) ? word[7:0] : 8'h00;
      r.count   = cnt;
      r.msg_end = last;
      bytes_decoded += cnt;
      expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void compare(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_bytes(input decoded_t got);
      decoded_t want;
      checked++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction waiting, expected none, actual %p",
                 $time, got);
        return;
      end
      want = expected_bytes.pop_front();
      compare("byte_first", want.first, got.first);
      compare("byte_second", want.second, got.second);
      compare("byte_third", want.third, got.third);
      compare("byte_count", 8'(want.count), 8'(got.count));
      compare("message_end", 8'(want.msg_end), 8'(got.msg_end));
      compare("halted", 8'(want.stop), 8'(got.stop));
    endfunction
  endclass
endpackage

module base64_stream_decoder_top_test;
  import b64d_pkg::*;
  import b64_check_pkg::*;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 64;
  localparam int IDLE_LIMIT   = 1000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] character = 8'h00;
  logic       message_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [1:0] byte_count;
  logic       message_end;
  logic       halted;

  base64_byte_ledger ledger = new();
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;
  bit pause_done = 1'b0;

  base64_stream_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .message_last (message_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_first   (byte_first),
    .byte_second  (byte_second),
    .byte_third   (byte_third),
    .byte_count   (byte_count),
    .message_end  (message_end),
    .halted       (halted)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    character    <= c;
    message_last <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    ledger.note_character(c, last);
    items_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_alpha();
    return char_of_sextet(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] random_stop_char();
    logic [7:0] c;
    logic [5:0] s;
    do c = 8'($urandom_range(0, 255)); while (sextet_of_char(c, s));
    return c;
  endfunction

  task automatic send_message();
    logic [7:0] msg[$];
    int kind;
    int groups;
    int tail;
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      groups = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(0, 4);
      tail   = $urandom_range(0, 5);
      repeat (groups * 4) msg = {msg, random_alpha()};
      case (tail)
        1: msg = {msg, random_alpha()};
        2: repeat (2) msg = {msg, random_alpha()};
        3: repeat (3) msg = {msg, random_alpha()};
        4: begin
          repeat (2) msg = {msg, random_alpha()};
          repeat (2) msg = {msg, CHAR_PAD};
        end
        5: begin
          repeat (3) msg = {msg, random_alpha()};
          msg = {msg, CHAR_PAD};
        end
        default: ;
      endcase
      if (msg.size() == 0) msg = {msg, random_alpha()};
      if (kind >= 75) msg.insert($urandom_range(0, msg.size()), random_stop_char());
    end else begin
      repeat ($urandom_range(1, 8)) msg = {msg, 8'($urandom_range(0, 255))};
    end
    for (int i = 0; i < msg.size(); i++)
      send_char(msg[i], i == msg.size() - 1);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      ledger.check_bytes('{byte_first, byte_second, byte_third, byte_count, message_end,
                           halted});
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && ledger.checked >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("** base64_stream_decoder_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int directed;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_string("AZaz09+/");
    send_string("TWE=");
    send_string("TQ==");
    send_string("Q");
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("c", 1'b0);
    send_char("d", 1'b1);
    send_char(8'h00, 1'b1);
    directed = items_sent;

    while (items_sent < directed + RANDOM_ITEMS) begin
      calm = (items_sent >= 700 && items_sent < 1000);
      if (!pause_done && items_sent >= 1300) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_message();
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d characters in %0d messages, %0d of them halted early.",
             items_sent, ledger.messages, ledger.halted_messages);
    $display("Checked %0d results carrying %0d decoded bytes, %0d errors.",
             ledger.checked, ledger.bytes_decoded, ledger.errors);
    if (ledger.errors == 0) begin
      $display("** base64_stream_decoder_top: PASSED **");
    end else begin
      $display("** base64_stream_decoder_top: FAILED **");
    end
    $finish;
  end
endmodule
